// File: design/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, types and helpers of the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int D_W       = 66;                 // |b*b - 4ac| < 2^66
   localparam int SQ_W      = 34;                 // floor sqrt < 2^33
   localparam int NMAG_W    = 34;                 // |-b +/- s| < 2^34
   localparam int NUM_W     = NMAG_W + FRAC_BITS; // dividend
   localparam int DEN_W     = COEF_W + 1;         // 2|a|
   localparam int Q_W       = 33;                 // quotient bits kept
   localparam int CMP_W     = DEN_W + Q_W;        // divider compare width
   localparam int TR_W      = D_W + 2;            // sqrt trial width
   localparam int NS_W      = NMAG_W + 2;         // signed numerator width

   typedef enum logic [1:0] {
      KIND_DISTINCT = 2'd0,
      KIND_EQUAL    = 2'd1,
      KIND_COMPLEX  = 2'd2
   } kind_type;

   // words riding alongside the square root stages
   typedef struct packed {
      logic                     valid;
      logic                     zero_a;
      logic                     dneg;
      logic                     dzero;
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
   } side_type;

   typedef struct packed {
      logic [D_W-1:0]  rem;
      logic [SQ_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic             valid;
      logic             zero_a;
      kind_type         kind;
      logic [DEN_W-1:0] den;
      logic [NUM_W-1:0] rem1;
      logic [NUM_W-1:0] rem2;
      logic [Q_W-1:0]   q1;
      logic [Q_W-1:0]   q2;
      logic             neg1;
      logic             neg2;
      logic             sat1;
      logic             sat2;
   } dv_type;

   typedef struct packed {
      logic [COEF_W-1:0] value;
      logic              ovf;
   } sat_word_type;

   function automatic logic [COEF_W-1:0] mag32(input logic [COEF_W-1:0] v);
      return v[COEF_W-1] ? (~v + 1'b1) : v;
   endfunction

   // apply sign to a truncated quotient and clamp to the 32-bit range
   function automatic sat_word_type sat_root(input logic [Q_W-1:0] q, input logic neg_flag,
                                             input logic sat);
      sat_word_type r;
      logic         neg;
      neg = neg_flag && (sat || q != '0);
      r.ovf = 1'b0;
      if (!neg) begin
         if (sat || q > Q_W'(32'h7FFF_FFFF)) begin
            r.value = 32'h7FFF_FFFF;
            r.ovf   = 1'b1;
         end else begin
            r.value = q[COEF_W-1:0];
         end
      end else begin
         if (sat || q > Q_W'(32'h8000_0000)) begin
            r.value = 32'h8000_0000;
            r.ovf   = 1'b1;
         end else begin
            r.value = ~q[COEF_W-1:0] + 1'b1;
         end
      end
      return r;
   endfunction

endpackage

// File: design/quadratic_root_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// A new coefficient word is taken every cycle (busy stays low) and its result
// appears on the rsp_ ports for one cycle, flagged by rsp_valid, once two
// stages form b*b and 4ac and the discriminant, 34 stages resolve one
// square-root bit each, one stage builds the numerators, 33 stages resolve
// one quotient bit each for both roots in parallel, and a last stage
// saturates. The receiver cannot stall, so no result is held.
module quadratic_root_solver_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_quad,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_lin,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_const,
   output logic                              rsp_valid,
   output logic signed [qrs_pkg::COEF_W-1:0] rsp_first_root,
   output logic signed [qrs_pkg::COEF_W-1:0] rsp_second_root,
   output logic [1:0]                        rsp_root_kind,
   output logic                              rsp_zero_lead_error,
   output logic                              rsp_overflow_flag
);

   localparam int W = qrs_pkg::COEF_W;

   assign busy = 1'b0;

   // ---------------- stage 1: products ----------------
   logic                  p_valid_ff;
   logic                  p_zero_a_ff;
   logic                  p_diff_ff;
   logic signed [W-1:0]   p_a_ff, p_b_ff;
   logic [2*W-1:0]        p_bb_ff;
   logic [qrs_pkg::D_W-1:0] p_ac4_ff;
   logic [2*W-1:0]        p_ac_in;

   assign p_ac_in = qrs_pkg::mag32(req_coef_quad) * qrs_pkg::mag32(req_coef_const);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= start;
      end
      p_zero_a_ff <= (req_coef_quad == '0);
      p_diff_ff   <= req_coef_quad[W-1] ^ req_coef_const[W-1];
      p_a_ff      <= req_coef_quad;
      p_b_ff      <= req_coef_lin;
      p_bb_ff     <= qrs_pkg::mag32(req_coef_lin) * qrs_pkg::mag32(req_coef_lin);
      p_ac4_ff    <= {p_ac_in, 2'b00};
   end

   // ---------------- stage 2: discriminant ----------------
   qrs_pkg::side_type side_ff [0:qrs_pkg::SQ_W];
   qrs_pkg::sq_type   sq_ff   [0:qrs_pkg::SQ_W];

   logic [qrs_pkg::D_W:0] d_sum_in, d_pos_in, d_neg_in;

   always_comb begin
      d_sum_in = {3'b000, p_bb_ff} + {1'b0, p_ac4_ff};
      d_pos_in = {3'b000, p_bb_ff} - {1'b0, p_ac4_ff};
      d_neg_in = {1'b0, p_ac4_ff} - {3'b000, p_bb_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else begin
         side_ff[0].valid <= p_valid_ff;
      end
      side_ff[0].zero_a <= p_zero_a_ff;
      side_ff[0].a      <= p_a_ff;
      side_ff[0].b      <= p_b_ff;
      side_ff[0].dzero  <= 1'b0;
      sq_ff[0].root     <= '0;
      if (p_diff_ff) begin
         side_ff[0].dneg <= 1'b0;
         sq_ff[0].rem    <= d_sum_in[qrs_pkg::D_W-1:0];
      end else if (!d_pos_in[qrs_pkg::D_W]) begin
         side_ff[0].dneg <= 1'b0;
         sq_ff[0].rem    <= d_pos_in[qrs_pkg::D_W-1:0];
      end else begin
         side_ff[0].dneg <= 1'b1;
         sq_ff[0].rem    <= d_neg_in[qrs_pkg::D_W-1:0];
      end
   end

   // ---------------- square root: one bit per stage ----------------
   for (genvar j = 0; j < qrs_pkg::SQ_W; j++) begin : g_sqrt
      localparam int K = qrs_pkg::SQ_W - 1 - j;
      logic [qrs_pkg::TR_W-1:0] tr_in;
      logic                     take_in;

      always_comb begin
         tr_in   = (qrs_pkg::TR_W'(sq_ff[j].root) << (K + 1))
                 | (qrs_pkg::TR_W'(1) << (2 * K));
         take_in = qrs_pkg::TR_W'(sq_ff[j].rem) >= tr_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j+1].valid <= 1'b0;
         end else begin
            side_ff[j+1].valid <= side_ff[j].valid;
         end
         side_ff[j+1].zero_a <= side_ff[j].zero_a;
         side_ff[j+1].a      <= side_ff[j].a;
         side_ff[j+1].b      <= side_ff[j].b;
         side_ff[j+1].dneg   <= side_ff[j].dneg;
         // the full discriminant is still in the remainder at the first step
         side_ff[j+1].dzero  <= (j == 0) ? (sq_ff[j].rem == '0) : side_ff[j].dzero;
         if (take_in) begin
            sq_ff[j+1].rem  <= sq_ff[j].rem - tr_in[qrs_pkg::D_W-1:0];
            sq_ff[j+1].root <= sq_ff[j].root | (qrs_pkg::SQ_W'(1) << K);
         end else begin
            sq_ff[j+1].rem  <= sq_ff[j].rem;
            sq_ff[j+1].root <= sq_ff[j].root;
         end
      end
   end

   // ---------------- numerators ----------------
   qrs_pkg::dv_type dv_ff [0:qrs_pkg::Q_W];

   localparam int SL = qrs_pkg::SQ_W;
   logic signed [qrs_pkg::NS_W-1:0] nb_in, s_in, n1_in, n2_in;
   logic [qrs_pkg::NS_W-1:0]        m1_in, m2_in;
   qrs_pkg::kind_type               kind_in;

   always_comb begin
      nb_in = -qrs_pkg::NS_W'(side_ff[SL].b);
      s_in  = $signed({2'b00, sq_ff[SL].root});
      if (side_ff[SL].dneg) begin
         kind_in = qrs_pkg::KIND_COMPLEX;
         n1_in   = nb_in;
         n2_in   = s_in;
      end else if (side_ff[SL].dzero) begin
         kind_in = qrs_pkg::KIND_EQUAL;
         n1_in   = nb_in;
         n2_in   = nb_in;
      end else begin
         kind_in = qrs_pkg::KIND_DISTINCT;
         n1_in   = nb_in + s_in;
         n2_in   = nb_in - s_in;
      end
      m1_in = n1_in[qrs_pkg::NS_W-1] ? -n1_in : n1_in;
      m2_in = n2_in[qrs_pkg::NS_W-1] ? -n2_in : n2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0].valid <= 1'b0;
      end else begin
         dv_ff[0].valid <= side_ff[SL].valid;
      end
      dv_ff[0].zero_a <= side_ff[SL].zero_a;
      dv_ff[0].kind   <= kind_in;
      dv_ff[0].den    <= {qrs_pkg::mag32(side_ff[SL].a), 1'b0};
      dv_ff[0].rem1   <= qrs_pkg::NUM_W'(m1_in[qrs_pkg::NMAG_W-1:0]) << qrs_pkg::FRAC_BITS;
      dv_ff[0].rem2   <= qrs_pkg::NUM_W'(m2_in[qrs_pkg::NMAG_W-1:0]) << qrs_pkg::FRAC_BITS;
      dv_ff[0].q1     <= '0;
      dv_ff[0].q2     <= '0;
      dv_ff[0].neg1   <= n1_in[qrs_pkg::NS_W-1] ^ side_ff[SL].a[W-1];
      dv_ff[0].neg2   <= n2_in[qrs_pkg::NS_W-1] ^ side_ff[SL].a[W-1];
      dv_ff[0].sat1   <= 1'b0;
      dv_ff[0].sat2   <= 1'b0;
   end

   // ---------------- dividers: one quotient bit per stage ----------------
   for (genvar j = 0; j < qrs_pkg::Q_W; j++) begin : g_div
      localparam int I = qrs_pkg::Q_W - 1 - j;
      logic [qrs_pkg::CMP_W-1:0] dsh_in, big_in;
      logic                      take1_in, take2_in;

      always_comb begin
         dsh_in   = qrs_pkg::CMP_W'(dv_ff[j].den) << I;
         big_in   = qrs_pkg::CMP_W'(dv_ff[j].den) << qrs_pkg::Q_W;
         take1_in = qrs_pkg::CMP_W'(dv_ff[j].rem1) >= dsh_in;
         take2_in = qrs_pkg::CMP_W'(dv_ff[j].rem2) >= dsh_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1].valid <= 1'b0;
         end else begin
            dv_ff[j+1].valid <= dv_ff[j].valid;
         end
         dv_ff[j+1].zero_a <= dv_ff[j].zero_a;
         dv_ff[j+1].kind   <= dv_ff[j].kind;
         dv_ff[j+1].den    <= dv_ff[j].den;
         dv_ff[j+1].neg1   <= dv_ff[j].neg1;
         dv_ff[j+1].neg2   <= dv_ff[j].neg2;
         // quotient too large for the kept bits: flag on the untouched dividend
         if (j == 0) begin
            dv_ff[j+1].sat1 <= qrs_pkg::CMP_W'(dv_ff[j].rem1) >= big_in;
            dv_ff[j+1].sat2 <= qrs_pkg::CMP_W'(dv_ff[j].rem2) >= big_in;
         end else begin
            dv_ff[j+1].sat1 <= dv_ff[j].sat1;
            dv_ff[j+1].sat2 <= dv_ff[j].sat2;
         end
         if (take1_in) begin
            dv_ff[j+1].rem1 <= dv_ff[j].rem1 - dsh_in[qrs_pkg::NUM_W-1:0];
            dv_ff[j+1].q1   <= dv_ff[j].q1 | (qrs_pkg::Q_W'(1) << I);
         end else begin
            dv_ff[j+1].rem1 <= dv_ff[j].rem1;
            dv_ff[j+1].q1   <= dv_ff[j].q1;
         end
         if (take2_in) begin
            dv_ff[j+1].rem2 <= dv_ff[j].rem2 - dsh_in[qrs_pkg::NUM_W-1:0];
            dv_ff[j+1].q2   <= dv_ff[j].q2 | (qrs_pkg::Q_W'(1) << I);
         end else begin
            dv_ff[j+1].rem2 <= dv_ff[j].rem2;
            dv_ff[j+1].q2   <= dv_ff[j].q2;
         end
      end
   end

   // ---------------- output: sign and saturate ----------------
   localparam int QL = qrs_pkg::Q_W;
   qrs_pkg::sat_word_type r1_in, r2_in;

   always_comb begin
      r1_in = qrs_pkg::sat_root(dv_ff[QL].q1, dv_ff[QL].neg1, dv_ff[QL].sat1);
      r2_in = qrs_pkg::sat_root(dv_ff[QL].q2, dv_ff[QL].neg2, dv_ff[QL].sat2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= dv_ff[QL].valid;
      end
      if (dv_ff[QL].zero_a) begin
         rsp_first_root      <= '0;
         rsp_second_root     <= '0;
         rsp_root_kind       <= qrs_pkg::KIND_DISTINCT;
         rsp_zero_lead_error <= 1'b1;
         rsp_overflow_flag   <= 1'b0;
      end else begin
         rsp_first_root      <= r1_in.value;
         rsp_second_root     <= r2_in.value;
         rsp_root_kind       <= dv_ff[QL].kind;
         rsp_zero_lead_error <= 1'b0;
         rsp_overflow_flag   <= r1_in.ovf | r2_in.ovf;
      end
   end

endmodule

// File: verif/quadratic_root_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_checker
// Watches the coefficient and root channels of the quadratic root solver,
// predicts every root word from the accepted coefficients and compares.
// ----------------------------------------------------------------------------
module quadratic_root_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_quad,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_lin,
   input  logic signed [qrs_pkg::COEF_W-1:0] req_coef_const,
   input  logic                              rsp_valid,
   input  logic signed [qrs_pkg::COEF_W-1:0] rsp_first_root,
   input  logic signed [qrs_pkg::COEF_W-1:0] rsp_second_root,
   input  logic [1:0]                        rsp_root_kind,
   input  logic                              rsp_zero_lead_error,
   input  logic                              rsp_overflow_flag,
   output int                                fail_count,
   output int                                pending_roots,
   output int                                roots_seen
);

   typedef struct {
      logic [31:0]       first;
      logic [31:0]       second;
      qrs_pkg::kind_type kind;
      logic              zero_a;
      logic              ovf;
   } roots_word_type;

   roots_word_type expected_roots[$];

   // (n << F) / (2a) truncated toward zero, clamped to 32 bits
   function automatic logic [31:0] scaled_quotient(input logic signed [39:0] n,
                                                   input logic signed [39:0] a,
                                                   inout logic ovf);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      logic         neg;
      num = 128'(n < 0 ? -n : n) << qrs_pkg::FRAC_BITS;
      den = 128'(a < 0 ? -a : a) * 2;
      q = num / den;
      neg = ((n < 0) != (a < 0)) && q != 0;
      if (!neg) begin
         if (q > 128'h7FFF_FFFF) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return q[31:0];
      end
      if (q > 128'h8000_0000) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return ~q[31:0] + 1'b1;
   endfunction

   function automatic roots_word_type solve_roots(input logic signed [31:0] qa,
                                                  input logic signed [31:0] lb,
                                                  input logic signed [31:0] kc);
      roots_word_type     w;
      logic signed [71:0] disc;
      logic [71:0]        dmag;
      logic [39:0]        s;
      logic [39:0]        t;
      logic signed [39:0] a40;
      logic signed [39:0] b40;
      w.first = '0; w.second = '0; w.kind = qrs_pkg::KIND_DISTINCT; w.zero_a = 1'b0;
      w.ovf = 1'b0;
      if (qa == 0) begin
         w.zero_a = 1'b1;
         return w;
      end
      disc = 72'(lb) * 72'(lb) - 72'sd4 * 72'(qa) * 72'(kc);
      dmag = disc < 0 ? 72'(-disc) : 72'(disc);
      s = '0;
      for (int bit_i = 33; bit_i >= 0; bit_i--) begin
         t = s | (40'd1 << bit_i);
         if (80'(t) * 80'(t) <= 80'(dmag)) s = t;
      end
      a40 = 40'(qa);
      b40 = 40'(lb);
      if (disc < 0) begin
         w.kind = qrs_pkg::KIND_COMPLEX;
         w.first = scaled_quotient(-b40, a40, w.ovf);
         w.second = scaled_quotient($signed(s), a40, w.ovf);
      end else if (disc == 0) begin
         w.kind = qrs_pkg::KIND_EQUAL;
         w.first = scaled_quotient(-b40, a40, w.ovf);
         w.second = w.first;
      end else begin
         w.first = scaled_quotient(-b40 + $signed(s), a40, w.ovf);
         w.second = scaled_quotient(-b40 - $signed(s), a40, w.ovf);
      end
      return w;
   endfunction

   assign pending_roots = expected_roots.size();

   always @(posedge clock) begin
      roots_word_type want;
      if (reset) begin
         expected_roots.delete();
         fail_count <= 0;
         roots_seen <= 0;
      end else begin
         if (start && !busy)
            expected_roots.push_back(solve_roots(req_coef_quad, req_coef_lin,
                                                 req_coef_const));
         if (rsp_valid) begin
            roots_seen <= roots_seen + 1;
            if (expected_roots.size() == 0) begin
               $error("root word with no coefficients pending");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_roots.pop_front();
               if (rsp_first_root !== want.first ||
                   rsp_second_root !== want.second ||
                   rsp_root_kind !== want.kind ||
                   rsp_zero_lead_error !== want.zero_a ||
                   rsp_overflow_flag !== want.ovf) begin
                  fail_count <= fail_count + 1;
                  if (rsp_first_root !== want.first)
                     $error("first_root expected %h actual %h", want.first, rsp_first_root);
                  if (rsp_second_root !== want.second)
                     $error("second_root expected %h actual %h", want.second,
                            rsp_second_root);
                  if (rsp_root_kind !== want.kind)
                     $error("root_kind expected %0d actual %0d", want.kind, rsp_root_kind);
                  if (rsp_zero_lead_error !== want.zero_a)
                     $error("zero_lead_error expected %b actual %b", want.zero_a,
                            rsp_zero_lead_error);
                  if (rsp_overflow_flag !== want.ovf)
                     $error("overflow_flag expected %b actual %b", want.ovf,
                            rsp_overflow_flag);
               end
            end
         end
      end
   end

endmodule

// File: verif/tb_quadratic_root_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_core
// Drives coefficient words into the quadratic root solver: directed corner
// cases, then random mixes of real, repeated and complex roots with gaps.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_core;

   localparam int RANDOM_WORDS = 1700;
   localparam int WATCHDOG_MAX = 2000;
   localparam int DRAIN_CYCLES = 100;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic signed [qrs_pkg::COEF_W-1:0] req_coef_quad = '0;
   logic signed [qrs_pkg::COEF_W-1:0] req_coef_lin = '0;
   logic signed [qrs_pkg::COEF_W-1:0] req_coef_const = '0;
   logic                              rsp_valid;
   logic signed [qrs_pkg::COEF_W-1:0] rsp_first_root;
   logic signed [qrs_pkg::COEF_W-1:0] rsp_second_root;
   logic [1:0]                        rsp_root_kind;
   logic                              rsp_zero_lead_error;
   logic                              rsp_overflow_flag;
   int                                fail_count;
   int                                pending_roots;
   int                                roots_seen;
   int                                idle_count = 0;
   int                                words_sent = 0;

   always #2 clock = ~clock;

   quadratic_root_solver_core u_dut (.*);

   quadratic_root_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_MAX) begin
         $display("watchdog: no traffic for %0d cycles", idle_count);
         $display("FAIL quadratic_root_solver_core");
         $finish;
      end
   end

   // present one word and hold it until it is taken
   task automatic send_word(input logic [31:0] qa, input logic [31:0] lb,
                            input logic [31:0] kc);
      start <= 1'b1;
      req_coef_quad <= qa;
      req_coef_lin <= lb;
      req_coef_const <= kc;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic idle_burst(input bit allow);
      if (allow && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'(int'($urandom_range(32'h0008_0000)) - 32'h0004_0000);
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         3: return 32'(int'($urandom_range(20)) - 10) << qrs_pkg::FRAC_BITS;
         4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'(int'($urandom_range(6)) - 3);
      endcase
   endfunction

   initial begin
      logic [31:0] qa, lb, kc;
      logic [31:0] corner[6];
      corner = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero lead coefficient, then the extremes
      send_word(32'h0, 32'h1234_5678, 32'h8000_0000);
      send_word(32'h0, 32'h0, 32'h0);
      for (int i = 0; i < 6; i++) send_word(corner[i], corner[5 - i], corner[(i + 2) % 6]);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);  // roots 2 and 1
      send_word(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);  // repeated root
      send_word(32'h0001_0000, 32'h0, 32'h0001_0000);          // complex pair
      send_word(32'hFFFF_0000, 32'h0, 32'hFFFF_0000);          // complex, negative a
      send_word(32'h0000_0001, 32'h7FFF_FFFF, 32'h0);          // saturating root
      send_word(32'h0000_0001, 32'h8000_0000, 32'h0);
      send_word(32'h0000_0001, 32'h0, 32'h8000_0000);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         qa = pick_coef();
         case ($urandom_range(4))
            0: begin  // repeated root: b = 2ak with small a and k
               qa = 32'(int'($urandom_range(64)) - 32) << qrs_pkg::FRAC_BITS;
               lb = 32'(int'($urandom_range(40)) - 20);
               kc = lb * lb;
               lb = 32'(2) * lb * (qa >>> qrs_pkg::FRAC_BITS) << qrs_pkg::FRAC_BITS;
               kc = kc * (qa >>> qrs_pkg::FRAC_BITS) << qrs_pkg::FRAC_BITS;
               qa = qa >>> qrs_pkg::FRAC_BITS << qrs_pkg::FRAC_BITS;
            end
            default: begin
               lb = pick_coef();
               kc = pick_coef();
            end
         endcase
         if ($urandom_range(40) == 0) qa = '0;
         send_word(qa, lb, kc);
         idle_burst(n < RANDOM_WORDS - 200);
      end
      start <= 1'b0;
      while (pending_roots != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d coefficient words, checked %0d root words", words_sent, roots_seen);
      $display("covered zero lead, distinct, repeated, complex and saturating roots");
      if (fail_count == 0) $display("PASS quadratic_root_solver_core");
      else $display("FAIL quadratic_root_solver_core");
      $finish;
   end

endmodule
